// ----- design/plr_pkg.sv -----
// Shared types, constants and helpers for the projected line rasterizer.
`default_nettype none
package plr_pkg;

  localparam int FB_WIDTH    = 320;
  localparam int FB_HEIGHT   = 200;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_PROJ_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 2'd2;

  localparam logic [7:0] PROJ_SCALE_RST = 8'd70;
  localparam logic [8:0] CENTER_X_RST   = 9'd160;
  localparam logic [7:0] CENTER_Y_RST   = 8'd100;

  localparam logic [1:0] STATUS_PIXEL   = 2'd0;
  localparam logic [1:0] STATUS_BEHIND  = 2'd1;
  localparam logic [1:0] STATUS_OFFSCR  = 2'd2;
  localparam logic [1:0] STATUS_NO_SEG  = 2'd3;

  localparam logic [1:0] STEP_NONE  = 2'd0;
  localparam logic [1:0] STEP_PLUS  = 2'd1;
  localparam logic [1:0] STEP_MINUS = 2'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] start_depth;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic signed [23:0] end_depth;
    logic [7:0]        color;
  } plr_in_t;

  typedef struct packed {
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_address;
    logic [7:0]  pixel_color;
    logic [1:0]  status;
    logic        last;
  } plr_out_t;

  // Handshake toward the serial divider.
  typedef struct packed {
    logic              start;
    logic signed [31:0] dividend;
    logic [23:0]       divisor;
  } plr_div_req_t;

  function automatic plr_out_t make_result(input logic [8:0] x, input logic [7:0] y,
                                           input logic [7:0] col, input logic [1:0] st,
                                           input logic lst);
    plr_out_t r;
    logic [25:0] addr;
    addr = 26'(y) * 26'(FB_WIDTH) + 26'(x);
    r.pixel_x       = x;
    r.pixel_y       = y;
    r.pixel_address = addr[15:0];
    r.pixel_color   = col;
    r.status        = st;
    r.last          = lst;
    return r;
  endfunction

  function automatic logic [8:0] apply_step9(input logic [8:0] v, input logic [1:0] code);
    logic [8:0] r;
    r = v;
    if (code == STEP_PLUS) r = v + 9'd1;
    else if (code == STEP_MINUS) r = v - 9'd1;
    return r;
  endfunction

  function automatic logic [7:0] apply_step8(input logic [7:0] v, input logic [1:0] code);
    logic [7:0] r;
    r = v;
    if (code == STEP_PLUS) r = v + 8'd1;
    else if (code == STEP_MINUS) r = v - 8'd1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/plr_fifo.sv -----
// Small register queue between the request front and the drawing back end.
`default_nettype none
module plr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_pop,
  output logic [WIDTH-1:0]      rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) count <= count + CW'(1);
      else if (!do_wr && do_rd) count <= count - CW'(1);
    end
  end
endmodule
`default_nettype wire

// ----- design/plr_div.sv -----
// Bit-serial signed divider by a positive depth, quotient truncated toward zero.
`default_nettype none
module plr_div (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire plr_pkg::plr_div_req_t req,
  output logic                       done,
  output logic signed [31:0]         quotient
);
  import plr_pkg::*;

  logic        run;
  logic [4:0]  cnt;
  logic [30:0] q;
  logic [23:0] rem;
  logic [23:0] div;
  logic        neg;
  logic [31:0] mag;
  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;

  assign mag   = req.dividend[31] ? 32'(-req.dividend) : 32'(req.dividend);
  assign trial = {rem, q[30]};
  assign diff  = trial - {1'b0, div};
  assign ge    = (trial >= {1'b0, div});
  assign quotient = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (req.start) begin
      q   <= mag[30:0];
      rem <= '0;
      div <= req.divisor;
      neg <= req.dividend[31];
    end else if (run) begin
      rem <= ge ? diff[23:0] : trial[23:0];
      q   <= {q[29:0], ge};
    end
  end
endmodule
`default_nettype wire

// ----- design/plr_engine.sv -----
// Back end: projects segment endpoints, checks them and walks pixels.
`default_nettype none
module plr_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire plr_pkg::plr_in_t  head,
  output logic                   pop,
  input  wire logic [7:0]        proj_scale,
  input  wire logic [8:0]        center_x,
  input  wire logic [7:0]        center_y,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output plr_pkg::plr_out_t      res
);
  import plr_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_START, S_WAIT, S_SETUP} state_t;

  state_t           state;
  plr_in_t          item;
  logic [1:0]       idx;
  logic signed [31:0] prod;
  logic [8:0]       px0, px1;
  logic [7:0]       py0, py1;
  logic             offscr;

  logic             busy;
  logic [8:0]       cur_x;
  logic [7:0]       cur_y;
  logic [8:0]       error_acc;
  logic [1:0]       step_x, step_y;
  logic [8:0]       abs_dx, abs_dy;
  logic             x_major;
  logic [8:0]       remaining;
  logic [7:0]       line_color;

  logic             out_free;
  logic             res_load;
  logic signed [23:0] coord_sel;
  logic signed [23:0] depth_sel;
  logic [8:0]       center_sel;
  logic signed [32:0] mul;
  plr_div_req_t     dreq;
  logic             ddone;
  logic signed [31:0] dq;
  logic signed [33:0] sum;
  logic             sum_ok;

  logic [8:0]       major, minor;
  logic [9:0]       acc;
  logic             acc_ge;
  logic [8:0]       err_step;
  logic [8:0]       nx;
  logic [7:0]       ny;
  logic [8:0]       rem_dec;

  logic signed [9:0] dx;
  logic signed [8:0] dy;
  logic [8:0]       adx, ady;
  logic             xm;
  logic [8:0]       maj0;

  assign out_free = !res_valid || res_ready;

  // A result beat is loaded on a next-pixel beat, a rejected start or a finished setup.
  assign res_load = ((state == S_IDLE) && head_valid && out_free &&
                     (head.req_type == REQ_NEXT || head.start_depth <= 0 ||
                      head.end_depth <= 0)) ||
                    ((state == S_SETUP) && out_free);

  always_comb begin
    unique case (idx)
      2'd0: begin coord_sel = item.start_x; depth_sel = item.start_depth;
                  center_sel = center_x; end
      2'd1: begin coord_sel = item.start_y; depth_sel = item.start_depth;
                  center_sel = 9'(center_y); end
      2'd2: begin coord_sel = item.end_x; depth_sel = item.end_depth;
                  center_sel = center_x; end
      default: begin coord_sel = item.end_y; depth_sel = item.end_depth;
                     center_sel = 9'(center_y); end
    endcase
  end

  assign mul           = $signed({1'b0, proj_scale}) * coord_sel;
  assign dreq.start    = (state == S_START);
  assign dreq.dividend = prod;
  assign dreq.divisor  = depth_sel[23:0];

  plr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (ddone),
    .quotient (dq)
  );

  assign sum    = 34'(dq) + $signed({25'b0, center_sel});
  assign sum_ok = !sum[33] && (idx[0] ? (sum < 34'(FB_HEIGHT))
                                      : (sum < 34'(FB_WIDTH)));

  // Next-pixel step of the active segment.
  always_comb begin
    major  = x_major ? abs_dx : abs_dy;
    minor  = x_major ? abs_dy : abs_dx;
    acc    = {1'b0, error_acc} + {1'b0, minor};
    acc_ge = (acc >= {1'b0, major});
    err_step = acc_ge ? 9'(acc - {1'b0, major}) : acc[8:0];
    nx = cur_x;
    ny = cur_y;
    if (acc_ge) begin
      if (x_major) ny = apply_step8(cur_y, step_y);
      else nx = apply_step9(cur_x, step_x);
    end
    if (x_major) nx = apply_step9(nx, step_x);
    else ny = apply_step8(ny, step_y);
    rem_dec = remaining - 9'd1;
  end

  // Segment setup from the projected endpoints.
  always_comb begin
    dx   = $signed({1'b0, px1}) - $signed({1'b0, px0});
    dy   = $signed({1'b0, py1}) - $signed({1'b0, py0});
    adx  = dx[9] ? 9'(-dx) : 9'(dx);
    ady  = dy[8] ? 9'(-dy) : 9'(dy);
    xm   = (adx > ady);
    maj0 = xm ? adx : ady;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      busy       <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      error_acc  <= '0;
      step_x     <= STEP_NONE;
      step_y     <= STEP_NONE;
      abs_dx     <= '0;
      abs_dy     <= '0;
      x_major    <= 1'b0;
      remaining  <= '0;
      line_color <= '0;
      idx        <= '0;
      offscr     <= 1'b0;
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (head_valid && out_free) begin
            if (head.req_type == REQ_NEXT) begin
              if (!busy) begin
                res <= make_result('0, '0, '0, STATUS_NO_SEG, 1'b1);
              end else begin
                error_acc <= err_step;
                cur_x     <= nx;
                cur_y     <= ny;
                remaining <= rem_dec;
                busy      <= (rem_dec != '0);
                res <= make_result(nx, ny, line_color, STATUS_PIXEL, rem_dec == '0);
              end
            end else begin
              busy      <= 1'b0;
              remaining <= '0;
              if (head.start_depth <= 0 || head.end_depth <= 0) begin
                res <= make_result('0, '0, '0, STATUS_BEHIND, 1'b1);
              end else begin
                item   <= head;
                idx    <= '0;
                offscr <= 1'b0;
                state  <= S_MUL;
              end
            end
          end
        end
        S_MUL: begin
          prod  <= mul[31:0];
          state <= S_START;
        end
        S_START: state <= S_WAIT;
        S_WAIT: begin
          if (ddone) begin
            if (!sum_ok) offscr <= 1'b1;
            unique case (idx)
              2'd0: px0 <= sum[8:0];
              2'd1: py0 <= sum[7:0];
              2'd2: px1 <= sum[8:0];
              default: py1 <= sum[7:0];
            endcase
            idx   <= idx + 2'd1;
            state <= (idx == 2'd3) ? S_SETUP : S_MUL;
          end
        end
        default: begin
          if (out_free) begin
            state     <= S_IDLE;
            if (offscr) begin
              res <= make_result('0, '0, '0, STATUS_OFFSCR, 1'b1);
            end else begin
              abs_dx     <= adx;
              abs_dy     <= ady;
              step_x     <= (dx > 0) ? STEP_PLUS : ((dx < 0) ? STEP_MINUS : STEP_NONE);
              step_y     <= (dy > 0) ? STEP_PLUS : ((dy < 0) ? STEP_MINUS : STEP_NONE);
              x_major    <= xm;
              remaining  <= maj0;
              error_acc  <= maj0 >> 1;
              cur_x      <= px0;
              cur_y      <= py0;
              line_color <= item.color;
              busy       <= (maj0 != '0);
              res <= make_result(px0, py0, item.color, STATUS_PIXEL, maj0 == '0);
            end
          end
        end
      endcase
    end
  end

  assign pop = (state == S_IDLE) && head_valid && out_free;
endmodule
`default_nettype wire

// ----- design/projected_line_rasterizer.sv -----
// Top level: request queue, projection and line-walking back end, config registers.
`default_nettype none
// Projected line rasterizer. A start beat projects both endpoints with a
// bit-serial divider (one quotient bit per cycle, four divisions in turn), so
// the first pixel of a segment comes out after the four divisions, or through
// the queue and then the result register when a depth is not positive. A
// next-pixel beat passes through the queue, then the result register, and such
// beats can follow one per cycle while the receiver takes each result.
// A two-entry queue takes requests while the back end works, and the result
// register holds a beat until it is taken. Config registers: 0 projection
// scale, 1 center_x, 2 center_y; writes to other indexes are ignored.
module projected_line_rasterizer #(
  parameter int QUEUE_DEPTH = plr_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire plr_pkg::plr_in_t                 req,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output plr_pkg::plr_out_t                     res,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [plr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [plr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import plr_pkg::*;

  logic [7:0] proj_scale;
  logic [8:0] center_x;
  logic [7:0] center_y;
  logic       head_valid;
  logic       pop;
  plr_in_t    head;
  logic [$bits(plr_in_t)-1:0] head_bits;

  assign cfg_ready = 1'b1;
  assign head      = plr_in_t'(head_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_scale <= PROJ_SCALE_RST;
      center_x   <= CENTER_X_RST;
      center_y   <= CENTER_Y_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROJ_SCALE: proj_scale <= cfg_data[7:0];
        CFG_CENTER_X:   center_x   <= cfg_data;
        CFG_CENTER_Y:   center_y   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  plr_fifo #(
    .WIDTH ($bits(plr_in_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (req_valid),
    .wr_ready (req_ready),
    .wr_data  (req),
    .rd_valid (head_valid),
    .rd_pop   (pop),
    .rd_data  (head_bits)
  );

  plr_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .proj_scale  (proj_scale),
    .center_x    (center_x),
    .center_y    (center_y),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the projected line rasterizer: pixel predictor and random traffic.
module testbench;
  import plr_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int IN_W = $bits(plr_in_t);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  class pixel_scoreboard;
    bit [7:0] scale;
    bit [8:0] cx;
    bit [7:0] cy;
    bit busy;
    bit [8:0] cur_x;
    bit [7:0] cur_y;
    int unsigned err_acc, adx, ady, remaining;
    bit [1:0] sx, sy;
    bit xmaj;
    bit [7:0] col;
    plr_out_t pending[$];
    int errors;

    function new();
      scale = PROJ_SCALE_RST;
      cx = CENTER_X_RST;
      cy = CENTER_Y_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_PROJ_SCALE) scale = data[7:0];
      else if (idx == CFG_CENTER_X) cx = data;
      else if (idx == CFG_CENTER_Y) cy = data[7:0];
    endfunction

    function void push_pixel(bit [8:0] x, bit [7:0] y, bit [7:0] c, bit [1:0] st, bit lst);
      plr_out_t r;
      int unsigned addr;
      addr = y * FB_WIDTH + x;
      r.pixel_x = x;
      r.pixel_y = y;
      r.pixel_address = addr[15:0];
      r.pixel_color = c;
      r.status = st;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function longint project(longint coord, longint depth, longint center);
      return (longint'(scale) * coord) / depth + center;
    endfunction

    function bit [1:0] dir_of(longint d);
      return d > 0 ? STEP_PLUS : (d < 0 ? STEP_MINUS : STEP_NONE);
    endfunction

    function bit [8:0] move9(bit [8:0] v, bit [1:0] code);
      if (code == STEP_PLUS) return v + 9'd1;
      if (code == STEP_MINUS) return v - 9'd1;
      return v;
    endfunction

    function bit [7:0] move8(bit [7:0] v, bit [1:0] code);
      if (code == STEP_PLUS) return v + 8'd1;
      if (code == STEP_MINUS) return v - 8'd1;
      return v;
    endfunction

    function void note(plr_in_t it);
      longint x0, y0, x1, y1, dx, dy;
      int unsigned major, minor;
      if (it.req_type == REQ_START) begin
        busy = 0;
        remaining = 0;
        if (it.start_depth <= 0 || it.end_depth <= 0) begin
          push_pixel('0, '0, '0, STATUS_BEHIND, 1'b1);
          return;
        end
        x0 = project(it.start_x, it.start_depth, cx);
        y0 = project(it.start_y, it.start_depth, cy);
        x1 = project(it.end_x, it.end_depth, cx);
        y1 = project(it.end_y, it.end_depth, cy);
        if (x0 < 0 || x0 >= FB_WIDTH || x1 < 0 || x1 >= FB_WIDTH ||
            y0 < 0 || y0 >= FB_HEIGHT || y1 < 0 || y1 >= FB_HEIGHT) begin
          push_pixel('0, '0, '0, STATUS_OFFSCR, 1'b1);
          return;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        adx = 32'(dx < 0 ? -dx : dx);
        ady = 32'(dy < 0 ? -dy : dy);
        sx = dir_of(dx);
        sy = dir_of(dy);
        xmaj = adx > ady;
        remaining = xmaj ? adx : ady;
        err_acc = remaining >> 1;
        cur_x = x0[8:0];
        cur_y = y0[7:0];
        col = it.color;
        busy = remaining != 0;
        push_pixel(cur_x, cur_y, col, STATUS_PIXEL, !busy);
        return;
      end
      if (!busy) begin
        push_pixel('0, '0, '0, STATUS_NO_SEG, 1'b1);
        return;
      end
      major = xmaj ? adx : ady;
      minor = xmaj ? ady : adx;
      err_acc += minor;
      if (err_acc >= major) begin
        err_acc -= major;
        if (xmaj) cur_y = move8(cur_y, sy);
        else cur_x = move9(cur_x, sx);
      end
      if (xmaj) cur_x = move9(cur_x, sx);
      else cur_y = move8(cur_y, sy);
      remaining -= 1;
      if (remaining == 0) busy = 0;
      push_pixel(cur_x, cur_y, col, STATUS_PIXEL, !busy);
    endfunction

    function void check(plr_out_t got);
      plr_out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.pixel_address !== want.pixel_address || got.pixel_color !== want.pixel_color ||
          got.status !== want.status || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected x=%0d y=%0d addr=%0d col=%0d st=%0d last=%0d,",
                   want.pixel_x, want.pixel_y, want.pixel_address, want.pixel_color,
                   want.status, want.last,
                   " got x=%0d y=%0d addr=%0d col=%0d st=%0d last=%0d",
                   got.pixel_x, got.pixel_y, got.pixel_address,
                   got.pixel_color, got.status, got.last);
      end
    endfunction
  endclass

  logic clk, rst;
  logic req_valid, req_ready, res_valid, res_ready, cfg_valid, cfg_ready;
  plr_in_t req;
  plr_out_t res;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_scoreboard sb;
  int send_idle, recv_stall;
  int hold_trigger, hold_seen, hold_cnt;
  int quiet_cycles;

  projected_line_rasterizer dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 0;
      hold_cnt <= 0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_cnt <= HOLD_CYCLES;
      res_ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      res_ready <= 0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(negedge clk) begin
    if (!rst && res_valid && res_ready) sb.check(res);
  end

  always @(negedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(plr_in_t it);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= it;
    req_valid <= 1;
    do @(negedge clk); while (!req_ready);
    sb.note(it);
    @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1;
    do @(negedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic plr_in_t seg(int sx, int sy, int sd, int ex, int ey, int ed, int c);
    plr_in_t it;
    it = '0;
    it.req_type = REQ_START;
    it.start_x = 24'(sx); it.start_y = 24'(sy); it.start_depth = 24'(sd);
    it.end_x = 24'(ex); it.end_y = 24'(ey); it.end_depth = 24'(ed);
    it.color = 8'(c);
    return it;
  endfunction

  function automatic plr_in_t noise();
    plr_in_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic plr_in_t next_req();
    plr_in_t it;
    it = noise();
    it.req_type = REQ_NEXT;
    return it;
  endfunction

  // Back-project one screen coordinate so it lands near p at the given depth.
  function automatic int camera_of(int p, int center, int depth);
    int s;
    s = sb.scale == 0 ? 1 : sb.scale;
    return ((p - center) * depth) / s;
  endfunction

  function automatic plr_in_t good_seg(bit long_line);
    int px0, py0, px1, py1, d0, d1, span;
    span = long_line ? 319 : $urandom_range(0, 12);
    px0 = $urandom_range(0, FB_WIDTH - 1);
    py0 = $urandom_range(0, FB_HEIGHT - 1);
    px1 = px0 + $urandom_range(0, 2 * span) - span;
    py1 = py0 + $urandom_range(0, 2 * span) - span;
    if (px1 < 0) px1 = 0;
    if (px1 >= FB_WIDTH) px1 = FB_WIDTH - 1;
    if (py1 < 0) py1 = 0;
    if (py1 >= FB_HEIGHT) py1 = FB_HEIGHT - 1;
    d0 = $urandom_range(1, 3000);
    d1 = $urandom_range(0, 3) == 0 ? d0 : $urandom_range(1, 3000);
    return seg(camera_of(px0, sb.cx, d0), camera_of(py0, sb.cy, d0), d0,
               camera_of(px1, sb.cx, d1), camera_of(py1, sb.cy, d1), d1,
               $urandom_range(0, 255));
  endfunction

  task automatic walk_segment();
    while (sb.busy) send(next_req());
  endtask

  task automatic run_random(int count);
    int sent;
    plr_in_t it;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        send(good_seg($urandom_range(39) == 0));
        sent++;
        while (sb.busy && $urandom_range(19) != 0) begin
          send(next_req());
          sent++;
        end
        // Send one more next-pixel beat now and then; it runs past the end if the segment is done.
        if ($urandom_range(3) == 0) begin
          send(next_req());
          sent++;
        end
      end else begin
        it = noise();
        if ($urandom_range(2) == 0) it.start_depth = -24'($urandom_range(0, 9));
        if ($urandom_range(2) == 0) it.end_depth = 24'($urandom_range(0, 4)) - 24'd2;
        send(it);
        sent++;
      end
      if (sent == count / 2 && $urandom_range(3) == 0) drain();
    end
  endtask

  task automatic set_config(int scale_v, int cx_v, int cy_v);
    drain();
    cfg_write(CFG_PROJ_SCALE, CFG_DATA_W'(scale_v));
    cfg_write(CFG_CENTER_X, CFG_DATA_W'(cx_v));
    cfg_write(CFG_CENTER_Y, CFG_DATA_W'(cy_v));
    cfg_valid <= 0;
  endtask

  initial begin
    sb = new();
    rst = 1;
    req_valid = 0;
    req = '0;
    cfg_valid = 0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_trigger = 0;
    hold_seen = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default config, depth 70 maps camera offsets one to one onto pixels.
    send(next_req());
    send(seg(0, 0, 0, 0, 0, 70, 1));
    send(seg(0, 0, 70, 0, 0, -1, 2));
    send(seg(8388607, -8388608, -8388608, -8388608, 8388607, -8388608, 3));
    send(seg(8388607, 8388607, 1, 0, 0, 70, 4));
    send(seg(-8388608, -8388608, 8388607, 0, 0, 8388607, 5));
    send(seg(-160, -100, 70, -160, -100, 70, 6));
    send(seg(159, 99, 70, 159, 99, 70, 7));
    send(seg(160, 0, 70, 160, 0, 70, 8));
    send(seg(-5, 0, 70, 5, 0, 70, 9));
    walk_segment();
    send(next_req());
    send(seg(0, 4, 70, 0, -4, 70, 10));
    walk_segment();
    send(seg(-3, -3, 70, 3, 3, 70, 255));
    walk_segment();
    send(seg(2, -7, 70, -1, 6, 70, 0));
    send(next_req());
    send(seg(-20, 10, 35, 20, -10, 140, 11));
    send(next_req());
    walk_segment();
    drain();

    cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
    cfg_valid <= 0;

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_config(1, 0, 0);
        1: set_config(255, 319, 199);
        2: set_config(70, 160, 100);
        3: set_config(9'h100, 100, 50);
        5: set_config(9'h1FF, 9'h1FF, 9'h1FF);
        default: set_config($urandom_range(1, 255), $urandom_range(0, 319),
                             $urandom_range(0, 199));
      endcase
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 54; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 54; end
        default: begin send_idle = 7; recv_stall = 7; end
      endcase
      if (phase == 2) hold_trigger = hold_trigger + 1;
      run_random(55);
      if (phase == 1) drain();
      run_random(55);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
